FILE: rtl/grain_pkg.sv
// grain_pkg: shared types and constants for the grain v1 keystream generator
// used by grain_core, grain_ctrl and the top level; no dependencies
package grain_pkg;

    localparam int REG_BITS  = 80;
    localparam int IV_BITS   = 64;
    localparam int KEY_LO_W  = 64;
    localparam int KEY_HI_W  = 16;
    localparam int CNT_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 6;

    localparam logic [CNT_W-1:0] MAX_BYTES      = 7'd64;
    localparam logic [CNT_W-1:0] BYTE_COUNT_RST = 7'd10;

    // register indexes on the configuration port
    localparam logic [1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [1:0] REG_BYTE_COUNT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_GEN
    } state_t;

    // control from the sequencer to the shift registers
    typedef struct packed {
        logic load;
        logic advance;
        logic init_fb;
    } core_ctl_t;

endpackage

FILE: rtl/grain_v1_keystream_generator_core.sv
// grain_v1_keystream_generator_core: top level with apb key and count registers
// depends on grain_pkg, grain_core and grain_ctrl
//
// channel   ports                               direction  width
// input     s_valid s_ready s_iv                in         64
// result    m_valid m_ready m_keystream_byte    out        8 + 1
//           m_last
// config    psel penable pwrite paddr pwdata    apb        64
//           prdata pready
//
// a request is loaded from s_iv, then runs the init rounds, and then packs the keystream
// into bytes of 8 bits; the single shift register pair makes one bit per cycle, held when
// a finished byte finds the output register full. reset is synchronous and active low and
// clears control state, the key and the byte count (to 10). a stalled result holds
// the generator only when the next byte is complete and the output register is full.
module grain_v1_keystream_generator_core
    import grain_pkg::*;
#(
    parameter int INIT_ROUNDS = 160
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [IV_BITS-1:0] s_iv,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [BYTE_W-1:0]  m_keystream_byte,
    output logic               m_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [KEY_LO_W-1:0] key_low_reg;
    logic [KEY_HI_W-1:0] key_high_reg;
    logic [CNT_W-1:0]    byte_count_reg;
    logic [1:0]          reg_idx;
    logic                wr_en;
    logic                z;
    core_ctl_t           ctl;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            byte_count_reg <= BYTE_COUNT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KEY_LOW:    key_low_reg    <= pwdata;
                REG_KEY_HIGH:   key_high_reg   <= pwdata[KEY_HI_W-1:0];
                REG_BYTE_COUNT: byte_count_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY_LOW:    prdata = key_low_reg;
            REG_KEY_HIGH:   prdata = {48'd0, key_high_reg};
            REG_BYTE_COUNT: prdata = {57'd0, byte_count_reg};
            default:        prdata = '0;
        endcase
    end

    grain_core u_core (
        .aclk (aclk),
        .ctl  (ctl),
        .key  ({key_high_reg, key_low_reg}),
        .iv   (s_iv),
        .z    (z)
    );

    grain_ctrl #(
        .INIT_ROUNDS (INIT_ROUNDS)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .byte_count       (byte_count_reg),
        .z                (z),
        .ctl              (ctl),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_keystream_byte (m_keystream_byte),
        .m_last           (m_last)
    );

endmodule

FILE: rtl/grain_core.sv
// grain_core: the 80-bit nonlinear and linear shift registers, one clock per cycle while advance is set
// depends on grain_pkg for widths and the control struct
module grain_core
    import grain_pkg::*;
(
    input  logic                  aclk,
    input  core_ctl_t             ctl,
    input  logic [REG_BITS-1:0]   key,
    input  logic [IV_BITS-1:0]    iv,
    output logic                  z
);

    logic [REG_BITS-1:0] nfsr_reg, nfsr_next;
    logic [REG_BITS-1:0] lfsr_reg, lfsr_next;
    logic                nf, lf;
    logic                x0, x1, x2, x3, x4;

    assign x0 = lfsr_reg[3];
    assign x1 = lfsr_reg[25];
    assign x2 = lfsr_reg[46];
    assign x3 = lfsr_reg[64];
    assign x4 = nfsr_reg[63];

    always_comb begin
        z = nfsr_reg[1] ^ nfsr_reg[2] ^ nfsr_reg[4] ^ nfsr_reg[10] ^ nfsr_reg[31]
            ^ nfsr_reg[43] ^ nfsr_reg[56]
            ^ x1 ^ x4 ^ (x0 & x3) ^ (x2 & x3) ^ (x3 & x4)
            ^ (x0 & x1 & x2) ^ (x0 & x2 & x3) ^ (x0 & x2 & x4)
            ^ (x1 & x2 & x4) ^ (x2 & x3 & x4);

        nf = lfsr_reg[0] ^ nfsr_reg[62] ^ nfsr_reg[60] ^ nfsr_reg[52] ^ nfsr_reg[45]
            ^ nfsr_reg[37] ^ nfsr_reg[33] ^ nfsr_reg[28] ^ nfsr_reg[21] ^ nfsr_reg[14]
            ^ nfsr_reg[9] ^ nfsr_reg[0]
            ^ (nfsr_reg[63] & nfsr_reg[60]) ^ (nfsr_reg[37] & nfsr_reg[33])
            ^ (nfsr_reg[15] & nfsr_reg[9])
            ^ (nfsr_reg[60] & nfsr_reg[52] & nfsr_reg[45])
            ^ (nfsr_reg[33] & nfsr_reg[28] & nfsr_reg[21])
            ^ (nfsr_reg[63] & nfsr_reg[45] & nfsr_reg[28] & nfsr_reg[9])
            ^ (nfsr_reg[60] & nfsr_reg[52] & nfsr_reg[37] & nfsr_reg[33])
            ^ (nfsr_reg[63] & nfsr_reg[60] & nfsr_reg[21] & nfsr_reg[15])
            ^ (nfsr_reg[63] & nfsr_reg[60] & nfsr_reg[52] & nfsr_reg[45] & nfsr_reg[37])
            ^ (nfsr_reg[33] & nfsr_reg[28] & nfsr_reg[21] & nfsr_reg[15] & nfsr_reg[9])
            ^ (nfsr_reg[52] & nfsr_reg[45] & nfsr_reg[37] & nfsr_reg[33]
               & nfsr_reg[28] & nfsr_reg[21]);

        lf = lfsr_reg[62] ^ lfsr_reg[51] ^ lfsr_reg[38] ^ lfsr_reg[23]
            ^ lfsr_reg[13] ^ lfsr_reg[0];
    end

    always_comb begin
        nfsr_next = nfsr_reg;
        lfsr_next = lfsr_reg;
        if (ctl.load) begin
            nfsr_next = key;
            lfsr_next = {{(REG_BITS-IV_BITS){1'b1}}, iv};
        end else if (ctl.advance) begin
            // index 0 is the oldest bit, new bit enters at the top
            nfsr_next = {nf ^ (ctl.init_fb & z), nfsr_reg[REG_BITS-1:1]};
            lfsr_next = {lf ^ (ctl.init_fb & z), lfsr_reg[REG_BITS-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        nfsr_reg <= nfsr_next;
        lfsr_reg <= lfsr_next;
    end

endmodule

FILE: rtl/grain_ctrl.sv
// grain_ctrl: sequencer for init and keystream clocks, byte packing and output register
// depends on grain_pkg for the state type, control struct and constants
module grain_ctrl
    import grain_pkg::*;
#(
    parameter int INIT_ROUNDS = 160
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CNT_W-1:0]   byte_count,
    input  logic               z,
    output core_ctl_t          ctl,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [BYTE_W-1:0]  m_keystream_byte,
    output logic               m_last
);

    localparam int RND_W = $clog2(INIT_ROUNDS + 1);
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(INIT_ROUNDS - 1);

    state_t              state_reg, state_next;
    logic [RND_W-1:0]    rnd_cnt_reg, rnd_cnt_next;
    logic [2:0]          bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]    byte_idx_reg, byte_idx_next;
    logic [BYTE_W-1:0]   byte_sr_reg, byte_sr_next;
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_byte_reg, m_byte_next;
    logic                m_last_reg, m_last_next;
    logic [CNT_W-1:0]    byte_lim;
    logic                step, byte_done, last_byte, init_done;

    assign byte_lim  = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
    assign last_byte = (({1'b0, byte_idx_reg}) + 7'd1) == byte_lim;
    assign init_done = rnd_cnt_reg == RND_LAST;
    // a finished byte waits while the output register is still full
    assign step      = !((bit_cnt_reg == 3'd7) && m_valid_reg && !m_ready);
    assign byte_done = (state_reg == ST_GEN) && step && (bit_cnt_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_INIT;
            end
            ST_INIT: begin
                if (init_done) state_next = (byte_lim == '0) ? ST_IDLE : ST_GEN;
            end
            ST_GEN: begin
                if (byte_done && last_byte) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        ctl.load    = 1'b0;
        ctl.advance = 1'b0;
        ctl.init_fb = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                ctl.load = s_valid;
            end
            ST_INIT: begin
                ctl.advance = 1'b1;
                ctl.init_fb = 1'b1;
            end
            ST_GEN: begin
                ctl.advance = step;
            end
            default: ;
        endcase
    end

    always_comb begin
        rnd_cnt_next  = rnd_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_idx_next = byte_idx_reg;
        byte_sr_next  = byte_sr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        if (ctl.load) begin
            rnd_cnt_next  = '0;
            bit_cnt_next  = '0;
            byte_idx_next = '0;
        end
        if (state_reg == ST_INIT) rnd_cnt_next = rnd_cnt_reg + 1'b1;
        if ((state_reg == ST_GEN) && step) begin
            // earliest bit ends up in bit 0
            byte_sr_next = {z, byte_sr_reg[BYTE_W-1:1]};
            bit_cnt_next = bit_cnt_reg + 3'd1;
        end
        if (byte_done) begin
            m_valid_next  = 1'b1;
            m_byte_next   = {z, byte_sr_reg[BYTE_W-1:1]};
            m_last_next   = last_byte;
            byte_idx_next = byte_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rnd_cnt_reg  <= '0;
            bit_cnt_reg  <= '0;
            byte_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rnd_cnt_reg  <= rnd_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_idx_reg <= byte_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_sr_reg <= byte_sr_next;
        m_byte_reg  <= m_byte_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_keystream_byte = m_byte_reg;
    assign m_last           = m_last_reg;

endmodule
